[rtl/core/imu_bias_pkg.sv]
// Package for the IMU bias calibration and correction block.
// Holds the shared widths, sample types and the status struct of the calibration unit.
// No dependencies.
package imu_bias_pkg;

  // field and state widths
  localparam int DATA_W = 16;           // one raw or corrected sample
  localparam int OFS_W  = 17;           // stored offset
  localparam int SUM_W  = 24;           // running sum of one axis
  localparam int GRAV_W = 15;           // gravity count register
  localparam int AXES   = 3;

  // defaults
  localparam int CAL_SAMPLES_DEF = 250;
  localparam logic [GRAV_W-1:0] GRAV_RESET = 15'd2048;

  typedef logic signed [DATA_W-1:0] sample_t;
  typedef logic signed [OFS_W-1:0]  ofs_t;

  // status of one calibration unit for the step in progress
  typedef struct packed {
    logic first;        // step is the first sample of a calibration
    logic active_next;  // calibration still running after this step
  } cal_stat_t;

endpackage

[rtl/core/imu_bias_corr.sv]
// Offset correction for one three-axis sensor: sample minus offset, saturated to 16 bits.
// Depends on imu_bias_pkg.
module imu_bias_corr (
  input  imu_bias_pkg::sample_t raw  [imu_bias_pkg::AXES],
  input  imu_bias_pkg::ofs_t    offs [imu_bias_pkg::AXES],
  output imu_bias_pkg::sample_t corr [imu_bias_pkg::AXES]
);

  localparam int DIFF_W = imu_bias_pkg::OFS_W + 1;
  localparam logic signed [DIFF_W-1:0] MAX_V = DIFF_W'(32767);
  localparam logic signed [DIFF_W-1:0] MIN_V = -DIFF_W'(32768);

  logic signed [DIFF_W-1:0] diff [imu_bias_pkg::AXES];

  // subtract and clamp each axis
  always_comb begin
    for (int i = 0; i < imu_bias_pkg::AXES; i++) begin
      diff[i] = DIFF_W'(raw[i]) - DIFF_W'(offs[i]);
      if (diff[i] > MAX_V) begin
        corr[i] = imu_bias_pkg::sample_t'(MAX_V[imu_bias_pkg::DATA_W-1:0]);
      end else if (diff[i] < MIN_V) begin
        corr[i] = imu_bias_pkg::sample_t'(MIN_V[imu_bias_pkg::DATA_W-1:0]);
      end else begin
        corr[i] = diff[i][imu_bias_pkg::DATA_W-1:0];
      end
    end
  end

endmodule

[rtl/core/imu_bias_cal.sv]
// Bias calibration unit for one three-axis sensor: sums, sample count, offsets.
// Divides the final sums by CAL_SAMPLES through a constant reciprocal multiply.
// Depends on imu_bias_pkg.
module imu_bias_cal #(
  parameter int CAL_SAMPLES = imu_bias_pkg::CAL_SAMPLES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,   // an item advances this cycle
  input  logic                              req,    // calibration request of that item
  input  logic                              hold,   // skip the calibration step
  input  logic [imu_bias_pkg::GRAV_W-1:0]   grav,   // taken off the z offset
  input  imu_bias_pkg::sample_t             vals [imu_bias_pkg::AXES],
  output imu_bias_pkg::ofs_t                offs [imu_bias_pkg::AXES],
  output imu_bias_pkg::cal_stat_t           stat
);

  localparam int SUM_W   = imu_bias_pkg::SUM_W;
  localparam int OFS_W   = imu_bias_pkg::OFS_W;
  localparam int CNT_W   = $clog2(CAL_SAMPLES + 1);
  // reciprocal: exact floor division for every magnitude below 2^SUM_W
  localparam int DIV_SHIFT = SUM_W + $clog2(CAL_SAMPLES);
  localparam int MULT_W    = SUM_W - 24 + 26;
  localparam longint DIV_MULT_L =
    ((64'd1 << DIV_SHIFT) + longint'(CAL_SAMPLES) - 1) / longint'(CAL_SAMPLES);
  localparam logic [MULT_W-1:0] DIV_MULT = MULT_W'(DIV_MULT_L);
  localparam int PROD_W = SUM_W + MULT_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(CAL_SAMPLES);

  logic                     active;
  logic [CNT_W-1:0]         count;
  logic signed [SUM_W-1:0]  sums     [imu_bias_pkg::AXES];
  logic signed [SUM_W-1:0]  sums_next[imu_bias_pkg::AXES];
  logic [SUM_W-1:0]         mag      [imu_bias_pkg::AXES];
  logic [PROD_W-1:0]        prod     [imu_bias_pkg::AXES];
  logic [OFS_W-1:0]         quo      [imu_bias_pkg::AXES];
  imu_bias_pkg::ofs_t       avg      [imu_bias_pkg::AXES];
  logic                     act_eff;
  logic                     run;
  logic                     last;

  // step control
  always_comb begin
    act_eff          = active | req;
    run              = act_eff & ~hold;
    last             = run && (count == LAST_CNT);
    stat.first       = run && (count == '0);
    stat.active_next = act_eff & ~last;
  end

  // running sums and average, truncated toward zero
  always_comb begin
    for (int i = 0; i < imu_bias_pkg::AXES; i++) begin
      sums_next[i] = sums[i] + SUM_W'(vals[i]);
      mag[i]  = sums_next[i][SUM_W-1] ? unsigned'(-sums_next[i]) : unsigned'(sums_next[i]);
      prod[i] = PROD_W'(mag[i]) * PROD_W'(DIV_MULT);
      quo[i]  = prod[i][DIV_SHIFT +: OFS_W];
      avg[i]  = sums_next[i][SUM_W-1] ? -signed'(quo[i]) : signed'(quo[i]);
    end
  end

  // state update when an item passes
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b1;
      count  <= '0;
      for (int i = 0; i < imu_bias_pkg::AXES; i++) begin
        sums[i] <= '0;
        offs[i] <= '0;
      end
    end else if (step) begin
      active <= stat.active_next;
      if (run) begin
        if (count == '0) begin
          // first sample: clear everything
          count <= CNT_W'(1);
          for (int i = 0; i < imu_bias_pkg::AXES; i++) begin
            sums[i] <= '0;
            offs[i] <= '0;
          end
        end else begin
          count <= last ? '0 : count + CNT_W'(1);
          for (int i = 0; i < imu_bias_pkg::AXES; i++) begin
            sums[i] <= sums_next[i];
          end
          if (last) begin
            offs[0] <= avg[0];
            offs[1] <= avg[1];
            offs[2] <= avg[2] - signed'(OFS_W'(grav));
          end
        end
      end
    end
  end

endmodule

[rtl/core/imu_bias_calibrate_and_correct.sv]
// Top level of the IMU bias calibration and correction block.
// Depends on imu_bias_pkg, imu_bias_corr and imu_bias_cal.
//
// Usage:
//   Input items arrive on the s_ stream: six raw signed 16-bit samples in
//   s_tdata and the two calibration requests in s_tuser. Each item yields
//   exactly one result item on the m_ stream: six offset-corrected, saturated
//   samples in m_tdata and the two calibrating flags in m_tuser.
//   An accepted item lands in the input register; when the result register
//   has room, it is corrected, the calibration state is stepped and the result
//   register loads, and the result is then offered on the m_ stream. One item
//   per cycle is sustained while the receiver does not stall: the state
//   update, including the divide by CAL_SAMPLES through a reciprocal
//   multiply, fits the single pass from input register to result register.
//   When the receiver stalls the result register holds; one more item is
//   taken into the input register and then s_tready drops.
//   Reset empties both registers, zeroes offsets and sums, loads the gravity
//   count of 2048 and arms both calibrations, so the first item after reset
//   starts an accelerometer calibration. Users write gravity_counts through
//   cfg_wr_en / cfg_wr_data only while idle; the block does not enforce it.
module imu_bias_calibrate_and_correct #(
  parameter int CAL_SAMPLES = imu_bias_pkg::CAL_SAMPLES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // accel_x_raw, accel_y_raw, accel_z_raw, gyro_x_raw, gyro_y_raw, gyro_z_raw
  input  logic [95:0]                     s_tdata,
  // accel_cal_request, gyro_cal_request
  input  logic [1:0]                      s_tuser,
  // result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z
  output logic [95:0]                     m_tdata,
  // accel_calibrating, gyro_calibrating
  output logic [1:0]                      m_tuser,
  // gravity_counts register
  input  logic                            cfg_wr_en,
  input  logic [imu_bias_pkg::GRAV_W-1:0] cfg_wr_data
);

  localparam int DW = imu_bias_pkg::DATA_W;

  logic                          in_valid;
  imu_bias_pkg::sample_t         in_accel [imu_bias_pkg::AXES];
  imu_bias_pkg::sample_t         in_gyro  [imu_bias_pkg::AXES];
  logic                          in_areq;
  logic                          in_greq;
  logic                          out_valid;
  imu_bias_pkg::sample_t         out_accel[imu_bias_pkg::AXES];
  imu_bias_pkg::sample_t         out_gyro [imu_bias_pkg::AXES];
  logic                          out_acal;
  logic                          out_gcal;
  logic [imu_bias_pkg::GRAV_W-1:0] gravity_counts;
  logic                          advance;
  imu_bias_pkg::ofs_t            accel_offs[imu_bias_pkg::AXES];
  imu_bias_pkg::ofs_t            gyro_offs [imu_bias_pkg::AXES];
  imu_bias_pkg::sample_t         accel_corr[imu_bias_pkg::AXES];
  imu_bias_pkg::sample_t         gyro_corr [imu_bias_pkg::AXES];
  imu_bias_pkg::cal_stat_t       accel_stat;
  imu_bias_pkg::cal_stat_t       gyro_stat;

  // handshake
  assign advance  = in_valid & (~out_valid | m_tready);
  assign s_tready = ~in_valid | advance;
  assign m_tvalid = out_valid;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_counts <= imu_bias_pkg::GRAV_RESET;
    end else if (cfg_wr_en) begin
      gravity_counts <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      for (int i = 0; i < imu_bias_pkg::AXES; i++) begin
        in_accel[i] <= s_tdata[i*DW +: DW];
        in_gyro[i]  <= s_tdata[(i+imu_bias_pkg::AXES)*DW +: DW];
      end
      in_areq <= s_tuser[0];
      in_greq <= s_tuser[1];
    end
  end

  // offset correction
  imu_bias_corr u_accel_corr (
    .raw  (in_accel),
    .offs (accel_offs),
    .corr (accel_corr)
  );

  imu_bias_corr u_gyro_corr (
    .raw  (in_gyro),
    .offs (gyro_offs),
    .corr (gyro_corr)
  );

  // calibration; the first accel sample skips the gyro step
  imu_bias_cal #(.CAL_SAMPLES(CAL_SAMPLES)) u_accel_cal (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (in_areq),
    .hold (1'b0),
    .grav (gravity_counts),
    .vals (accel_corr),
    .offs (accel_offs),
    .stat (accel_stat)
  );

  imu_bias_cal #(.CAL_SAMPLES(CAL_SAMPLES)) u_gyro_cal (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (in_greq),
    .hold (accel_stat.first),
    .grav ('0),
    .vals (gyro_corr),
    .offs (gyro_offs),
    .stat (gyro_stat)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_accel <= accel_corr;
      out_gyro  <= gyro_corr;
      out_acal  <= accel_stat.active_next;
      out_gcal  <= gyro_stat.active_next;
    end
  end

  assign m_tdata = {out_gyro[2], out_gyro[1], out_gyro[0],
                    out_accel[2], out_accel[1], out_accel[0]};
  assign m_tuser = {out_gcal, out_acal};

endmodule

[sim/tb.sv]
// Self-checking bench for the IMU bias calibration and correction block.
// Drives the s_/m_ streams and the gravity register, and checks every result.
// Depends on imu_bias_pkg and imu_bias_calibrate_and_correct.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRAV_W   = imu_bias_pkg::GRAV_W;
  localparam int SUM_W    = imu_bias_pkg::SUM_W;
  localparam int ITEMS    = 1950;
  localparam int CAL_N    = imu_bias_pkg::CAL_SAMPLES_DEF;
  localparam int HOLD_CYC = 60;
  localparam int S_MAX    = 32767;
  localparam int S_MIN    = -32768;
  localparam int ACC      = 0;
  localparam int GYR      = 1;
  localparam logic [GRAV_W-1:0] GRAV_MAX = '1;

  typedef imu_bias_pkg::sample_t sample_t;
  typedef imu_bias_pkg::ofs_t    ofs_t;

  // one input item and one result item, laid out as on the bus
  typedef struct packed {
    logic g_req;
    logic a_req;
    sample_t [5:0] raw;   // accel x y z, gyro x y z
  } frame_t;

  typedef struct packed {
    logic g_cal;
    logic a_cal;
    sample_t [5:0] val;
  } result_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_mode_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [95:0] s_tdata;   // accel_x_raw .. gyro_z_raw
  logic [1:0] s_tuser;    // accel_cal_request, gyro_cal_request
  logic m_tvalid;
  logic m_tready;
  logic [95:0] m_tdata;   // accel_x .. gyro_z
  logic [1:0] m_tuser;    // accel_calibrating, gyro_calibrating
  logic cfg_wr_en;
  logic [GRAV_W-1:0] cfg_wr_data;

  imu_bias_calibrate_and_correct dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // bias model: index 0 is the accelerometer, 1 the gyro
  ofs_t                    bias_ofs [2][3];
  logic signed [SUM_W-1:0] bias_sum [2][3];
  logic [7:0]              cal_cnt [2];
  logic                    cal_on [2];
  logic [GRAV_W-1:0]       grav_model;

  result_t corrected_q [$];
  int n_sent;
  int n_checked;
  int n_err;
  int n_cal_done [2];
  int burst_left;
  logic hold_req;
  string axis_name [6] = '{"accel_x", "accel_y", "accel_z", "gyro_x", "gyro_y", "gyro_z"};

  // directed items right after reset: offsets are still zero, so each item must
  // come back unchanged with both calibrations running.
  // columns: accel x y z, gyro x y z, requests {gyro, accel}, flags {gyro, accel}
  localparam int DIR_N = 12;
  int dir_tab [DIR_N][8] = '{
    '{     0,      0,      0,      0,      0,      0, 0, 3},
    '{ 32767,  32767,  32767,  32767,  32767,  32767, 0, 3},
    '{-32768, -32768, -32768, -32768, -32768, -32768, 3, 3},
    '{    -1,     -1,     -1,     -1,     -1,     -1, 1, 3},
    '{     1,      1,      1,      1,      1,      1, 2, 3},
    '{ 21845, -21846,  21845, -21846,  21845, -21846, 0, 3},
    '{-21846,  21845, -21846,  21845, -21846,  21845, 1, 3},
    '{ 32767, -32768,  32767, -32768,  32767, -32768, 2, 3},
    '{-32768,  32767, -32768,  32767, -32768,  32767, 0, 3},
    '{   256,   -257,   4096,  -4097,  16384, -16385, 3, 3},
    '{     0,  32767,     -1, -32768,      1,      0, 0, 3},
    '{-32768, -32768, -32768, -32768, -32768, -32768, 3, 3}
  };

  function automatic int clamp16(int v);
    if (v > S_MAX) return S_MAX;
    if (v < S_MIN) return S_MIN;
    return v;
  endfunction

  function automatic void reset_model();
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < 3; i++) begin
        bias_ofs[s][i] = '0;
        bias_sum[s][i] = '0;
      end
      cal_cnt[s] = '0;
      cal_on[s] = 1'b1;
    end
    grav_model = imu_bias_pkg::GRAV_RESET;
  endfunction

  // one calibration step of one sensor; returns 1 on the first sample,
  // which ends the whole step
  function automatic logic cal_advance(int s, sample_t [2:0] v, int grav_z);
    int q;
    if (!cal_on[s]) return 1'b0;
    if (cal_cnt[s] == 0) begin
      for (int i = 0; i < 3; i++) begin
        bias_ofs[s][i] = '0;
        bias_sum[s][i] = '0;
      end
      cal_cnt[s] = 8'd1;
      return 1'b1;
    end
    cal_cnt[s] = cal_cnt[s] + 8'd1;
    for (int i = 0; i < 3; i++) bias_sum[s][i] = bias_sum[s][i] + $signed(v[i]);
    if (cal_cnt[s] == 8'(CAL_N + 1)) begin
      for (int i = 0; i < 3; i++) begin
        q = int'(bias_sum[s][i]) / CAL_N;   // truncates toward zero
        if (i == 2) q = q - grav_z;
        bias_ofs[s][i] = ofs_t'(q);
      end
      cal_cnt[s] = '0;
      cal_on[s] = 1'b0;
      n_cal_done[s]++;
    end
    return 1'b0;
  endfunction

  // corrected, saturated samples and calibration flags for one frame
  function automatic result_t correct_frame(frame_t f);
    result_t r;
    int d;
    for (int i = 0; i < 6; i++) begin
      d = int'($signed(f.raw[i])) - int'($signed(bias_ofs[i / 3][i % 3]));
      r.val[i] = sample_t'(clamp16(d));
    end
    if (f.a_req) cal_on[ACC] = 1'b1;
    if (f.g_req) cal_on[GYR] = 1'b1;
    if (!cal_advance(ACC, r.val[2:0], int'(grav_model)))
      void'(cal_advance(GYR, r.val[5:3], 0));
    r.a_cal = cal_on[ACC];
    r.g_cal = cal_on[GYR];
    return r;
  endfunction

  function automatic sample_t near(int mean, int amp);
    int v;
    v = mean + int'($urandom_range(0, 2 * amp)) - amp;
    return sample_t'(clamp16(v));
  endfunction

  // offer one item in bursts; called and returns at a falling edge
  task automatic offer_item(frame_t f, logic typed, result_t want);
    int gap;
    result_t pred;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid = 1'b1;
    s_tdata = f.raw;
    s_tuser = {f.g_req, f.a_req};
    do @(posedge clk); while (!s_tready);
    pred = correct_frame(f);
    corrected_q.push_back(typed ? want : pred);
    n_sent++;
    @(negedge clk);
  endtask

  // stop sending and wait until every expected result is back
  task automatic drain();
    s_tvalid = 1'b0;
    while (corrected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_gravity(logic [GRAV_W-1:0] g);
    drain();
    cfg_wr_en = 1'b1;
    cfg_wr_data = g;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    grav_model = g;
  endtask

  // optional calibration run with random content, then plain correction traffic
  task automatic run_phase(int idx);
    int mean [6];
    int amp [6];
    logic [1:0] req;
    int n_cal;
    int n_corr;
    frame_t f;
    result_t none;
    none = '0;
    case (idx)
      0: set_gravity(GRAV_MAX);
      1: set_gravity('0);
      2: set_gravity(imu_bias_pkg::GRAV_RESET);
      default: if ($urandom_range(0, 1) != 0) set_gravity(GRAV_W'($urandom_range(0, 32767)));
    endcase
    req = (idx == 0) ? 2'b00 : 2'($urandom_range(0, 3));
    n_cal = (idx == 0 || req != 2'b00) ? CAL_N + 6 : 0;
    n_corr = $urandom_range(20, 80);
    for (int i = 0; i < 6; i++) begin
      case ($urandom_range(0, 3))
        0: mean[i] = S_MAX;
        1: mean[i] = S_MIN;
        default: mean[i] = int'($signed(16'($urandom)));
      endcase
      case ($urandom_range(0, 3))
        0: amp[i] = 0;
        1: amp[i] = 15;
        2: amp[i] = 2000;
        default: amp[i] = 65535;
      endcase
    end
    // pin accel z low so the z offset, gravity included, comes near its floor
    if (idx == 0) begin
      mean[0] = S_MAX;
      amp[0] = 0;
      mean[2] = S_MIN;
      amp[2] = 0;
    end
    for (int k = 0; k < n_cal; k++) begin
      if (n_sent >= ITEMS) break;
      for (int i = 0; i < 6; i++) f.raw[i] = near(mean[i], amp[i]);
      {f.g_req, f.a_req} = 2'b00;
      if (k == 0) {f.g_req, f.a_req} = req;
      else if ($urandom_range(0, 63) == 0) {f.g_req, f.a_req} = 2'($urandom_range(1, 3));
      if ($urandom_range(0, 31) == 0) f.raw = {$urandom, $urandom, $urandom};
      offer_item(f, 1'b0, none);
      if ((idx == 1 && k == 0) || (idx == 3 && k == 100)) hold_req = 1'b1;
      if (idx == 2 && k == 128) drain();
    end
    for (int k = 0; k < n_corr; k++) begin
      if (n_sent >= ITEMS) break;
      f.raw = {$urandom, $urandom, $urandom};
      {f.g_req, f.a_req} = 2'b00;
      if ($urandom_range(0, 99) == 0) {f.g_req, f.a_req} = 2'($urandom_range(1, 3));
      offer_item(f, 1'b0, none);
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (corrected_q.size() == 0) begin
      $error("result item with nothing expected");
      n_err++;
      return;
    end
    want = corrected_q.pop_front();
    n_checked++;
    for (int i = 0; i < 6; i++)
      if (got.val[i] !== want.val[i]) begin
        $error("%s: expected %0d, got %0d", axis_name[i],
               $signed(want.val[i]), $signed(got.val[i]));
        n_err++;
      end
    if (got.a_cal !== want.a_cal) begin
      $error("accel_calibrating: expected %0b, got %0b", want.a_cal, got.a_cal);
      n_err++;
    end
    if (got.g_cal !== want.g_cal) begin
      $error("gyro_calibrating: expected %0b, got %0b", want.g_cal, got.g_cal);
      n_err++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_result({m_tuser, m_tdata});
  end

  // receiver: stall patterns that change over time, plus requested hold-offs
  initial begin
    rx_mode_t mode;
    int mode_left;
    int rx_tick;
    mode = RX_OPEN;
    mode_left = 0;
    rx_tick = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_req) begin
        m_tready = 1'b0;
        repeat (HOLD_CYC) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:   m_tready = 1'b1;
          RX_COIN:   m_tready = 1'($urandom_range(0, 1));
          RX_MOSTLY: m_tready = ($urandom_range(0, 7) != 0);
          default:   m_tready = ((rx_tick % 5) < 2);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    frame_t f;
    result_t want;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    n_sent = 0;
    n_checked = 0;
    n_err = 0;
    n_cal_done[ACC] = 0;
    n_cal_done[GYR] = 0;
    reset_model();
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int k = 0; k < DIR_N; k++) begin
      for (int i = 0; i < 6; i++) f.raw[i] = sample_t'(dir_tab[k][i]);
      {f.g_req, f.a_req} = 2'(dir_tab[k][6]);
      want.val = f.raw;
      {want.g_cal, want.a_cal} = 2'(dir_tab[k][7]);
      offer_item(f, 1'b1, want);
    end

    for (int p = 0; n_sent < ITEMS; p++) run_phase(p);

    drain();
    repeat (8) @(negedge clk);
    $display("tb summary: %0d items in, %0d results checked, %0d mismatches",
             n_sent, n_checked, n_err);
    $display("tb summary: %0d accel and %0d gyro calibrations completed",
             n_cal_done[ACC], n_cal_done[GYR]);
    if (n_err == 0 && corrected_q.size() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("tb: errors");
    $finish;
  end

endmodule
